>>> design/cau_pkg.sv
// Shared codes and control types for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_EQ   = 3'd4,
        MODE_NE   = 3'd5,
        MODE_MAG  = 3'd6,
        MODE_NONE = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } ctrl_t;

endpackage

`default_nettype wire

>>> design/cau_front.sv
// Front end: products, sums, and set-up of the divider and square root.
`timescale 1ns / 1ps
`default_nettype none

module cau_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2:0]            mode,
    input  wire logic signed [W-1:0]   a_re,
    input  wire logic signed [W-1:0]   a_im,
    input  wire logic signed [W-1:0]   b_re,
    input  wire logic signed [W-1:0]   b_im,
    output cau_pkg::ctrl_t             ctrl,
    output logic signed [W-1:0]        side_re,
    output logic signed [W-1:0]        side_im,
    output logic                       side_cmp,
    output cau_pkg::status_t           side_st,
    output logic [2*W+F-1:0]           nre_mag,
    output logic [2*W+F-1:0]           nim_mag,
    output logic                       nre_neg,
    output logic                       nim_neg,
    output logic                       nre_ovf,
    output logic                       nim_ovf,
    output logic [2*W-1:0]             den,
    output logic [2*W-1:0]             mag2
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int RW = 2 * W + F;
    localparam int CW = 3 * W + F;
    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [PW:0]   RND  = {{(PW+1-F){1'b0}}, {F{1'b1}}};

    // clamp to the W-bit range; top bit flags a clamp
    function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > MAXV)
            r = {1'b1, MAXV[W-1:0]};
        else if (v < MINV)
            r = {1'b1, MINV[W-1:0]};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // stage 1: products and plain sums
    cau_pkg::ctrl_t           c1_reg, c1_next;
    logic signed [PW-1:0]     prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [PW-1:0]     paa_reg, pai_reg, pbr_reg, pbi_reg;
    logic signed [W:0]        sre_reg, sim_reg, dre_reg, dim_reg;
    logic                     eq_reg;

    always_comb
    begin
        c1_next.valid = start;
        c1_next.mode  = cau_pkg::mode_t'(mode);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
        end
        else
        begin
            c1_reg <= c1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prr_reg <= PW'(a_re) * PW'(b_re);
        pii_reg <= PW'(a_im) * PW'(b_im);
        pri_reg <= PW'(a_re) * PW'(b_im);
        pir_reg <= PW'(a_im) * PW'(b_re);
        paa_reg <= PW'(a_re) * PW'(a_re);
        pai_reg <= PW'(a_im) * PW'(a_im);
        pbr_reg <= PW'(b_re) * PW'(b_re);
        pbi_reg <= PW'(b_im) * PW'(b_im);
        sre_reg <= (W+1)'(a_re) + (W+1)'(b_re);
        sim_reg <= (W+1)'(a_im) + (W+1)'(b_im);
        dre_reg <= (W+1)'(a_re) - (W+1)'(b_re);
        dim_reg <= (W+1)'(a_im) - (W+1)'(b_im);
        eq_reg  <= (a_re == b_re) && (a_im == b_im);
    end

    // stage 2: combine products
    cau_pkg::ctrl_t           c2_reg;
    logic signed [PW:0]       mre_reg, mim_reg, nre_reg, nim_reg;
    logic [PW-1:0]            den_reg, mag_reg;
    logic signed [W:0]        sre2_reg, sim2_reg, dre2_reg, dim2_reg;
    logic                     eq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
        end
        else
        begin
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mre_reg  <= (PW+1)'(prr_reg) - (PW+1)'(pii_reg);
        mim_reg  <= (PW+1)'(pri_reg) + (PW+1)'(pir_reg);
        nre_reg  <= (PW+1)'(prr_reg) + (PW+1)'(pii_reg);
        nim_reg  <= (PW+1)'(pir_reg) - (PW+1)'(pri_reg);
        den_reg  <= $unsigned(pbr_reg) + $unsigned(pbi_reg);
        mag_reg  <= $unsigned(paa_reg) + $unsigned(pai_reg);
        sre2_reg <= sre_reg;
        sim2_reg <= sim_reg;
        dre2_reg <= dre_reg;
        dim2_reg <= dim_reg;
        eq2_reg  <= eq_reg;
    end

    // stage 3: round products toward zero, clamp, set up the division
    logic signed [PW:0]  mre_t, mim_t;
    logic [W:0]          mre_s, mim_s, sre_s, sim_s, dre_s, dim_s;
    logic [PW-1:0]       nre_abs, nim_abs;
    logic [RW-1:0]       nre_sh, nim_sh;
    logic signed [W-1:0] side_re_next, side_im_next;
    logic                side_cmp_next;
    cau_pkg::status_t    side_st_next;

    always_comb
    begin
        mre_t   = $signed(mre_reg + (mre_reg[PW] ? RND : '0)) >>> F;
        mim_t   = $signed(mim_reg + (mim_reg[PW] ? RND : '0)) >>> F;
        mre_s   = sat_fn(SW'(mre_t));
        mim_s   = sat_fn(SW'(mim_t));
        sre_s   = sat_fn(SW'(sre2_reg));
        sim_s   = sat_fn(SW'(sim2_reg));
        dre_s   = sat_fn(SW'(dre2_reg));
        dim_s   = sat_fn(SW'(dim2_reg));
        nre_abs = nre_reg[PW] ? PW'(-nre_reg) : PW'(nre_reg);
        nim_abs = nim_reg[PW] ? PW'(-nim_reg) : PW'(nim_reg);
        nre_sh  = {nre_abs, {F{1'b0}}};
        nim_sh  = {nim_abs, {F{1'b0}}};

        side_re_next  = '0;
        side_im_next  = '0;
        side_cmp_next = 1'b0;
        side_st_next  = cau_pkg::ST_OK;
        unique case (c2_reg.mode)
            cau_pkg::MODE_ADD:
            begin
                side_re_next = sre_s[W-1:0];
                side_im_next = sim_s[W-1:0];
                if (sre_s[W] || sim_s[W])
                    side_st_next = cau_pkg::ST_SAT;
            end
            cau_pkg::MODE_SUB:
            begin
                side_re_next = dre_s[W-1:0];
                side_im_next = dim_s[W-1:0];
                if (dre_s[W] || dim_s[W])
                    side_st_next = cau_pkg::ST_SAT;
            end
            cau_pkg::MODE_MUL:
            begin
                side_re_next = mre_s[W-1:0];
                side_im_next = mim_s[W-1:0];
                if (mre_s[W] || mim_s[W])
                    side_st_next = cau_pkg::ST_SAT;
            end
            cau_pkg::MODE_EQ:
            begin
                side_cmp_next = eq2_reg;
            end
            cau_pkg::MODE_NE:
            begin
                side_cmp_next = !eq2_reg;
            end
            default:
            begin
                side_cmp_next = 1'b0;
            end
        endcase
    end

    cau_pkg::ctrl_t c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_reg <= '0;
        end
        else
        begin
            c3_reg <= c2_reg;
        end
    end

    logic signed [W-1:0] side_re_reg, side_im_reg;
    logic                side_cmp_reg;
    cau_pkg::status_t    side_st_reg;
    logic [RW-1:0]       nre_mag_reg, nim_mag_reg;
    logic                nre_neg_reg, nim_neg_reg, nre_ovf_reg, nim_ovf_reg;
    logic [PW-1:0]       den3_reg, mag3_reg;

    always_ff @(posedge clk)
    begin
        side_re_reg  <= side_re_next;
        side_im_reg  <= side_im_next;
        side_cmp_reg <= side_cmp_next;
        side_st_reg  <= side_st_next;
        nre_mag_reg  <= nre_sh;
        nim_mag_reg  <= nim_sh;
        nre_neg_reg  <= nre_reg[PW];
        nim_neg_reg  <= nim_reg[PW];
        // a quotient of 2^W or more always clamps
        nre_ovf_reg  <= CW'(nre_sh) >= (CW'(den_reg) << W);
        nim_ovf_reg  <= CW'(nim_sh) >= (CW'(den_reg) << W);
        den3_reg     <= den_reg;
        mag3_reg     <= mag_reg;
    end

    assign ctrl     = c3_reg;
    assign side_re  = side_re_reg;
    assign side_im  = side_im_reg;
    assign side_cmp = side_cmp_reg;
    assign side_st  = side_st_reg;
    assign nre_mag  = nre_mag_reg;
    assign nim_mag  = nim_mag_reg;
    assign nre_neg  = nre_neg_reg;
    assign nim_neg  = nim_neg_reg;
    assign nre_ovf  = nre_ovf_reg;
    assign nim_ovf  = nim_ovf_reg;
    assign den      = den3_reg;
    assign mag2     = mag3_reg;

endmodule

`default_nettype wire

>>> design/cau_stage.sv
// One pipeline step: a quotient bit for both divisions and one root bit.
`timescale 1ns / 1ps
`default_nettype none

module cau_stage #(
    parameter int W = 32,
    parameter int F = 16,
    parameter int K = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cau_pkg::ctrl_t          ctrl_in,
    input  wire logic signed [W-1:0] side_re_in,
    input  wire logic signed [W-1:0] side_im_in,
    input  wire logic               side_cmp_in,
    input  cau_pkg::status_t        side_st_in,
    input  wire logic [2*W+F-1:0]   rre_in,
    input  wire logic [2*W+F-1:0]   rim_in,
    input  wire logic [W-1:0]       qre_in,
    input  wire logic [W-1:0]       qim_in,
    input  wire logic               nre_neg_in,
    input  wire logic               nim_neg_in,
    input  wire logic               nre_ovf_in,
    input  wire logic               nim_ovf_in,
    input  wire logic [2*W-1:0]     den_in,
    input  wire logic [2*W-1:0]     sq_in,
    input  wire logic [W-1:0]       root_in,
    output cau_pkg::ctrl_t          ctrl_out,
    output logic signed [W-1:0]     side_re_out,
    output logic signed [W-1:0]     side_im_out,
    output logic                    side_cmp_out,
    output cau_pkg::status_t        side_st_out,
    output logic [2*W+F-1:0]        rre_out,
    output logic [2*W+F-1:0]        rim_out,
    output logic [W-1:0]            qre_out,
    output logic [W-1:0]            qim_out,
    output logic                    nre_neg_out,
    output logic                    nim_neg_out,
    output logic                    nre_ovf_out,
    output logic                    nim_ovf_out,
    output logic [2*W-1:0]          den_out,
    output logic [2*W-1:0]          sq_out,
    output logic [W-1:0]            root_out
);

    localparam int PW = 2 * W;
    localparam int RW = 2 * W + F;
    localparam int CW = 3 * W + F;

    logic [CW-1:0]   trial, ere, eim;
    logic [RW-1:0]   rre_next, rim_next;
    logic [W-1:0]    qre_next, qim_next, root_next;
    logic [PW:0]     inc, esq;
    logic [PW-1:0]   sq_next;

    always_comb
    begin
        trial    = CW'(den_in) << K;
        ere      = CW'(rre_in);
        eim      = CW'(rim_in);
        rre_next = rre_in;
        rim_next = rim_in;
        qre_next = qre_in;
        qim_next = qim_in;
        if (ere >= trial)
        begin
            rre_next = RW'(ere - trial);
            qre_next = qre_in | (W'(1) << K);
        end
        if (eim >= trial)
        begin
            rim_next = RW'(eim - trial);
            qim_next = qim_in | (W'(1) << K);
        end

        // (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
        inc       = ((PW+1)'(root_in) << (K + 1)) | ((PW+1)'(1) << (2 * K));
        esq       = (PW+1)'(sq_in);
        sq_next   = sq_in;
        root_next = root_in;
        if (esq >= inc)
        begin
            sq_next   = PW'(esq - inc);
            root_next = root_in | (W'(1) << K);
        end
    end

    cau_pkg::ctrl_t ctrl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    logic signed [W-1:0] side_re_reg, side_im_reg;
    logic                side_cmp_reg;
    cau_pkg::status_t    side_st_reg;
    logic [RW-1:0]       rre_reg, rim_reg;
    logic [W-1:0]        qre_reg, qim_reg, root_reg;
    logic                nre_neg_reg, nim_neg_reg, nre_ovf_reg, nim_ovf_reg;
    logic [PW-1:0]       den_reg, sq_reg;

    always_ff @(posedge clk)
    begin
        side_re_reg  <= side_re_in;
        side_im_reg  <= side_im_in;
        side_cmp_reg <= side_cmp_in;
        side_st_reg  <= side_st_in;
        rre_reg      <= rre_next;
        rim_reg      <= rim_next;
        qre_reg      <= qre_next;
        qim_reg      <= qim_next;
        nre_neg_reg  <= nre_neg_in;
        nim_neg_reg  <= nim_neg_in;
        nre_ovf_reg  <= nre_ovf_in;
        nim_ovf_reg  <= nim_ovf_in;
        den_reg      <= den_in;
        sq_reg       <= sq_next;
        root_reg     <= root_next;
    end

    assign ctrl_out     = ctrl_reg;
    assign side_re_out  = side_re_reg;
    assign side_im_out  = side_im_reg;
    assign side_cmp_out = side_cmp_reg;
    assign side_st_out  = side_st_reg;
    assign rre_out      = rre_reg;
    assign rim_out      = rim_reg;
    assign qre_out      = qre_reg;
    assign qim_out      = qim_reg;
    assign nre_neg_out  = nre_neg_reg;
    assign nim_neg_out  = nim_neg_reg;
    assign nre_ovf_out  = nre_ovf_reg;
    assign nim_ovf_out  = nim_ovf_reg;
    assign den_out      = den_reg;
    assign sq_out       = sq_reg;
    assign root_out     = root_reg;

endmodule

`default_nettype wire

>>> design/cau_back.sv
// Back end: sign and clamp the quotients and root, pick the result, register it.
`timescale 1ns / 1ps
`default_nettype none

module cau_back #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  cau_pkg::ctrl_t           ctrl_in,
    input  wire logic signed [W-1:0] side_re_in,
    input  wire logic signed [W-1:0] side_im_in,
    input  wire logic                side_cmp_in,
    input  cau_pkg::status_t         side_st_in,
    input  wire logic [W-1:0]        qre_in,
    input  wire logic [W-1:0]        qim_in,
    input  wire logic                nre_neg_in,
    input  wire logic                nim_neg_in,
    input  wire logic                nre_ovf_in,
    input  wire logic                nim_ovf_in,
    input  wire logic [2*W-1:0]      den_in,
    input  wire logic [W-1:0]        root_in,
    output logic                     done,
    output logic signed [W-1:0]      res_re,
    output logic signed [W-1:0]      res_im,
    output logic                     compare_true,
    output logic [1:0]               status
);

    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

    // signed quotient clamped; top bit flags a clamp
    function automatic logic [W:0] qsat(input logic [W-1:0] q, input logic neg,
                                        input logic ovf);
        logic [W:0] r;
        if (ovf)
            r = {1'b1, (neg ? HALF : MAXV)};
        else if (neg && (q > HALF))
            r = {1'b1, HALF};
        else if (neg)
            r = {1'b0, W'(-q)};
        else if (q >= HALF)
            r = {1'b1, MAXV};
        else
            r = {1'b0, q};
        return r;
    endfunction

    logic [W:0]          qre_s, qim_s;
    logic signed [W-1:0] re_next, im_next;
    logic                cmp_next;
    cau_pkg::status_t    st_next;

    always_comb
    begin
        qre_s    = qsat(qre_in, nre_neg_in, nre_ovf_in);
        qim_s    = qsat(qim_in, nim_neg_in, nim_ovf_in);
        re_next  = side_re_in;
        im_next  = side_im_in;
        cmp_next = side_cmp_in;
        st_next  = side_st_in;
        unique case (ctrl_in.mode)
            cau_pkg::MODE_DIV:
            begin
                cmp_next = 1'b0;
                if (den_in == '0)
                begin
                    re_next = '0;
                    im_next = '0;
                    st_next = cau_pkg::ST_DZ;
                end
                else
                begin
                    re_next = qre_s[W-1:0];
                    im_next = qim_s[W-1:0];
                    st_next = (qre_s[W] || qim_s[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::MODE_MAG:
            begin
                cmp_next = 1'b0;
                im_next  = '0;
                if (root_in >= HALF)
                begin
                    re_next = MAXV;
                    st_next = cau_pkg::ST_SAT;
                end
                else
                begin
                    re_next = root_in;
                    st_next = cau_pkg::ST_OK;
                end
            end
            default:
            begin
                cmp_next = side_cmp_in;
            end
        endcase
    end

    logic                done_reg;
    logic signed [W-1:0] re_reg, im_reg;
    logic                cmp_reg;
    cau_pkg::status_t    st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg  <= re_next;
        im_reg  <= im_next;
        cmp_reg <= cmp_next;
        st_reg  <= st_next;
    end

    assign done         = done_reg;
    assign res_re       = re_reg;
    assign res_im       = im_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule

`default_nettype wire

>>> design/complex_arithmetic_unit.sv
// Top level of the pipelined complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

// Complex arithmetic unit: add, subtract, multiply, divide, compare and
// magnitude on signed fixed-point complex operands (FRAC_BITS fraction bits).
//
// Input channel: drive mode and the four operand parts and raise start; the
// item is taken at any rising edge with start high and busy low. busy never
// rises, so an item can be taken on every cycle.
// Output channel: done is high for one cycle with res_re, res_im,
// compare_true and status; the receiver must take the item in that cycle.
//
// Pipeline: three front stages form the products and sums, DATA_WIDTH
// stages each yield one quotient bit of both divisions and one bit of the
// square root, and one stage clamps and registers the result.
// Throughput: one item per cycle, in every mode.
//
// Reset clears every valid bit at once; items in flight are dropped and no
// strobe follows until a new item is taken.

module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   mode,
    input  wire logic signed [DATA_WIDTH-1:0] a_re,
    input  wire logic signed [DATA_WIDTH-1:0] a_im,
    input  wire logic signed [DATA_WIDTH-1:0] b_re,
    input  wire logic signed [DATA_WIDTH-1:0] b_im,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      res_re,
    output logic signed [DATA_WIDTH-1:0]      res_im,
    output logic                              compare_true,
    output logic [1:0]                        status
);

    localparam int W       = DATA_WIDTH;
    localparam int RW      = 2 * DATA_WIDTH + FRAC_BITS;
    localparam int PW      = 2 * DATA_WIDTH;
    localparam int LATENCY = DATA_WIDTH + 4;

    // hand-off between stages; index 0 comes from the front end
    cau_pkg::ctrl_t      s_ctrl    [0:W];
    logic signed [W-1:0] s_side_re [0:W];
    logic signed [W-1:0] s_side_im [0:W];
    logic                s_cmp     [0:W];
    cau_pkg::status_t    s_st      [0:W];
    logic [RW-1:0]       s_rre     [0:W];
    logic [RW-1:0]       s_rim     [0:W];
    logic [W-1:0]        s_qre     [0:W];
    logic [W-1:0]        s_qim     [0:W];
    logic                s_nre_neg [0:W];
    logic                s_nim_neg [0:W];
    logic                s_nre_ovf [0:W];
    logic                s_nim_ovf [0:W];
    logic [PW-1:0]       s_den     [0:W];
    logic [PW-1:0]       s_sq      [0:W];
    logic [W-1:0]        s_root    [0:W];

    // no back-pressure anywhere in the pipe
    assign busy = 1'b0;

    cau_front #(
        .W (DATA_WIDTH),
        .F (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start && !busy),
        .mode     (mode),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .ctrl     (s_ctrl[0]),
        .side_re  (s_side_re[0]),
        .side_im  (s_side_im[0]),
        .side_cmp (s_cmp[0]),
        .side_st  (s_st[0]),
        .nre_mag  (s_rre[0]),
        .nim_mag  (s_rim[0]),
        .nre_neg  (s_nre_neg[0]),
        .nim_neg  (s_nim_neg[0]),
        .nre_ovf  (s_nre_ovf[0]),
        .nim_ovf  (s_nim_ovf[0]),
        .den      (s_den[0]),
        .mag2     (s_sq[0])
    );

    // quotient and root start empty; bits are decided from the top down
    assign s_qre[0]  = '0;
    assign s_qim[0]  = '0;
    assign s_root[0] = '0;

    for (genvar g = 0; g < W; g++)
    begin : g_step
        cau_stage #(
            .W (DATA_WIDTH),
            .F (FRAC_BITS),
            .K (DATA_WIDTH - 1 - g)
        ) u_stage (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl_in      (s_ctrl[g]),
            .side_re_in   (s_side_re[g]),
            .side_im_in   (s_side_im[g]),
            .side_cmp_in  (s_cmp[g]),
            .side_st_in   (s_st[g]),
            .rre_in       (s_rre[g]),
            .rim_in       (s_rim[g]),
            .qre_in       (s_qre[g]),
            .qim_in       (s_qim[g]),
            .nre_neg_in   (s_nre_neg[g]),
            .nim_neg_in   (s_nim_neg[g]),
            .nre_ovf_in   (s_nre_ovf[g]),
            .nim_ovf_in   (s_nim_ovf[g]),
            .den_in       (s_den[g]),
            .sq_in        (s_sq[g]),
            .root_in      (s_root[g]),
            .ctrl_out     (s_ctrl[g+1]),
            .side_re_out  (s_side_re[g+1]),
            .side_im_out  (s_side_im[g+1]),
            .side_cmp_out (s_cmp[g+1]),
            .side_st_out  (s_st[g+1]),
            .rre_out      (s_rre[g+1]),
            .rim_out      (s_rim[g+1]),
            .qre_out      (s_qre[g+1]),
            .qim_out      (s_qim[g+1]),
            .nre_neg_out  (s_nre_neg[g+1]),
            .nim_neg_out  (s_nim_neg[g+1]),
            .nre_ovf_out  (s_nre_ovf[g+1]),
            .nim_ovf_out  (s_nim_ovf[g+1]),
            .den_out      (s_den[g+1]),
            .sq_out       (s_sq[g+1]),
            .root_out     (s_root[g+1])
        );
    end

    cau_back #(
        .W (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_in      (s_ctrl[W]),
        .side_re_in   (s_side_re[W]),
        .side_im_in   (s_side_im[W]),
        .side_cmp_in  (s_cmp[W]),
        .side_st_in   (s_st[W]),
        .qre_in       (s_qre[W]),
        .qim_in       (s_qim[W]),
        .nre_neg_in   (s_nre_neg[W]),
        .nim_neg_in   (s_nim_neg[W]),
        .nre_ovf_in   (s_nre_ovf[W]),
        .nim_ovf_in   (s_nim_ovf[W]),
        .den_in       (s_den[W]),
        .root_in      (s_root[W]),
        .done         (done),
        .res_re       (res_re),
        .res_im       (res_im),
        .compare_true (compare_true),
        .status       (status)
    );

    // every taken item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("item did not emerge after the pipeline latency");

    // a true compare carries no numeric result and no error
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && compare_true |-> res_re == '0 && res_im == '0 &&
                                 status == cau_pkg::ST_OK)
        else $error("compare result carries data");

    // division by zero returns zero
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == cau_pkg::ST_DZ |-> res_re == '0 && res_im == '0)
        else $error("division by zero returned data");

    // only the defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == cau_pkg::ST_OK || status == cau_pkg::ST_DZ ||
                 status == cau_pkg::ST_SAT)
        else $error("undefined status code");

endmodule

`default_nettype wire
